FILE: sv/dvi_pkg.sv
// shared types, table constants and widths for the voltage interpolator
`timescale 1ns / 1ps

package dvi_pkg;

	// field widths
	localparam int FW = 24;
	localparam int VW = 20;

	// table storage: sixteen slots, unused slots repeat the last real point
	localparam int SLOTS = 16;
	localparam int IW    = $clog2(SLOTS);

	// divider geometry: quotient never exceeds the voltage span
	localparam int DW         = FW;
	localparam int QW         = VW;
	localparam int XW         = VW + FW;
	localparam int STEPS      = 2;
	localparam int DIV_STAGES = QW / STEPS;

	localparam logic [FW-1:0] FREQ_TAB [SLOTS] = '{
		24'd2093000, 24'd2002000, 24'd1794000, 24'd1540000,
		24'd1352000, 24'd1014000, 24'd845000,  24'd676000,
		24'd546000,  24'd421000,  24'd286000,  24'd208000,
		24'd208000,  24'd208000,  24'd208000,  24'd208000
	};

	localparam logic [VW-1:0] VOLT_TAB [SLOTS] = '{
		20'd918750, 20'd906250, 20'd893750, 20'd862500,
		20'd837500, 20'd800000, 20'd781250, 20'd756250,
		20'd700000, 20'd725000, 20'd712500, 20'd700000,
		20'd700000, 20'd700000, 20'd700000, 20'd700000
	};

	// partial state of the long division
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] xlo;
		logic [QW-1:0] quot;
	} div_state_t;

	// data that rides alongside the division
	typedef struct packed {
		logic [VW-1:0] base;
		logic          rise;
	} side_t;

	// one restoring division step: bring down a dividend bit, subtract if it fits
	function automatic div_state_t div_step(div_state_t a, logic [DW-1:0] d);
		logic [DW:0] t;
		logic        fit;
		div_state_t  r;
		t   = {a.rem, a.xlo[QW-1]};
		fit = (t >= {1'b0, d});
		r.rem  = fit ? DW'(t - {1'b0, d}) : t[DW-1:0];
		r.xlo  = {a.xlo[QW-2:0], 1'b0};
		r.quot = {a.quot[QW-2:0], fit};
		return r;
	endfunction

endpackage

FILE: sv/dvi_div.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
`timescale 1ns / 1ps

module dvi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld,
	input  logic [dvi_pkg::XW-1:0]    dividend,
	input  logic [dvi_pkg::DW-1:0]    divisor,
	input  dvi_pkg::side_t            side,
	output logic                      quot_vld,
	output logic [dvi_pkg::QW-1:0]    quot,
	output dvi_pkg::side_t            quot_side
);

	localparam int NS = dvi_pkg::DIV_STAGES;

	logic                   vld_s  [NS];
	dvi_pkg::div_state_t    st_s   [NS];
	logic [dvi_pkg::DW-1:0] dvs_s  [NS];
	dvi_pkg::side_t         side_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic                   vld_in;
		dvi_pkg::div_state_t    st_in;
		dvi_pkg::div_state_t    st_nx;
		logic [dvi_pkg::DW-1:0] dvs_in;
		dvi_pkg::side_t         side_in;

		// stage inputs: ports for the first stage, previous stage otherwise
		if (g == 0) begin : g_first
			assign vld_in       = vld;
			assign st_in.rem    = dividend[dvi_pkg::XW-1:dvi_pkg::QW];
			assign st_in.xlo    = dividend[dvi_pkg::QW-1:0];
			assign st_in.quot   = '0;
			assign dvs_in       = divisor;
			assign side_in      = side;
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign st_in   = st_s[g-1];
			assign dvs_in  = dvs_s[g-1];
			assign side_in = side_s[g-1];
		end

		// STEPS division steps in this stage, one quotient bit each
		always_comb begin
			st_nx = st_in;
			for (int k = 0; k < dvi_pkg::STEPS; k++) begin
				st_nx = dvi_pkg::div_step(st_nx, dvs_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			st_s[g]   <= st_nx;
			dvs_s[g]  <= dvs_in;
			side_s[g] <= side_in;
		end
	end

	assign quot_vld  = vld_s[NS-1];
	assign quot      = st_s[NS-1].quot;
	assign quot_side = side_s[NS-1];

	// the remainder stays below the divisor; checked in the first and the last stage
	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> st_s[0].rem < dvs_s[0])
		else $error("divider remainder out of range in first stage");

	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		quot_vld |-> st_s[NS-1].rem < dvs_s[NS-1])
		else $error("divider remainder out of range in last stage");

	// valid moves through the stages one per cycle
	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		quot_vld |-> $past(vld_s[0], NS-1))
		else $error("divider valid appeared without an entry");

endmodule

FILE: sv/dvfs_voltage_interpolator_top.sv
// top level: frequency to supply voltage by piecewise linear interpolation
`timescale 1ns / 1ps

// Takes one frequency request (kHz) in every clock cycle and returns the
// interpolated supply voltage (microvolts) with done high for one cycle. The
// pipeline registers the segment select, then the multiply, then ten divider
// stages of two quotient bits each, then one output add.
// busy is always low: the pipeline never stalls, and results cannot be held
// off by the receiver.
module dvfs_voltage_interpolator_top #(
	parameter int LEVELS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [dvi_pkg::FW-1:0] freq_khz,
	output logic                   done,
	output logic [dvi_pkg::VW-1:0] volt_uv
);

	localparam logic [dvi_pkg::IW-1:0] LAST = dvi_pkg::IW'(LEVELS - 1);
	localparam int LAT = dvi_pkg::DIV_STAGES + 3;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// segment select: first point at or below the request
	logic [dvi_pkg::IW-1:0] seg_c;
	logic                   hi_c;
	logic                   lo_c;
	logic [dvi_pkg::FW-1:0] fu_c;
	logic [dvi_pkg::FW-1:0] fd_c;
	logic [dvi_pkg::VW-1:0] vu_c;
	logic [dvi_pkg::VW-1:0] vd_c;

	always_comb begin
		seg_c = LAST;
		for (int i = dvi_pkg::SLOTS - 1; i >= 1; i--) begin
			if (i < LEVELS && freq_khz >= dvi_pkg::FREQ_TAB[i]) begin
				seg_c = dvi_pkg::IW'(i);
			end
		end
		hi_c = freq_khz >= dvi_pkg::FREQ_TAB[0];
		lo_c = freq_khz <= dvi_pkg::FREQ_TAB[LAST];
		fu_c = dvi_pkg::FREQ_TAB[seg_c - 1'b1];
		fd_c = dvi_pkg::FREQ_TAB[seg_c];
		vu_c = dvi_pkg::VOLT_TAB[seg_c - 1'b1];
		vd_c = dvi_pkg::VOLT_TAB[seg_c];
	end

	// stage 1: segment parameters; clamped requests get a zero voltage span
	logic                   vld_s1;
	dvi_pkg::side_t         side_s1;
	logic [dvi_pkg::VW-1:0] span_v_s1;
	logic [dvi_pkg::FW-1:0] span_f_s1;
	logic [dvi_pkg::FW-1:0] delta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (hi_c || lo_c) begin
			side_s1.base <= hi_c ? dvi_pkg::VOLT_TAB[0] : dvi_pkg::VOLT_TAB[LAST];
			side_s1.rise <= 1'b0;
			span_v_s1    <= '0;
			span_f_s1    <= dvi_pkg::FW'(1);
			delta_s1     <= '0;
		end else begin
			side_s1.base <= vu_c;
			side_s1.rise <= vu_c < vd_c;
			span_v_s1    <= (vu_c >= vd_c) ? vu_c - vd_c : vd_c - vu_c;
			span_f_s1    <= fu_c - fd_c;
			delta_s1     <= fu_c - freq_khz;
		end
	end

	// stage 2: voltage span times frequency offset
	logic                   vld_s2;
	dvi_pkg::side_t         side_s2;
	logic [dvi_pkg::XW-1:0] prod_s2;
	logic [dvi_pkg::FW-1:0] span_f_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2   <= side_s1;
		prod_s2   <= dvi_pkg::XW'(span_v_s1) * dvi_pkg::XW'(delta_s1);
		span_f_s2 <= span_f_s1;
	end

	// divide by the frequency span
	logic                   div_vld;
	logic [dvi_pkg::QW-1:0] div_q;
	dvi_pkg::side_t         div_side;

	dvi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_s2),
		.dividend  (prod_s2),
		.divisor   (span_f_s2),
		.side      (side_s2),
		.quot_vld  (div_vld),
		.quot      (div_q),
		.quot_side (div_side)
	);

	// output: step away from the upper point's voltage
	logic                   done_q;
	logic [dvi_pkg::VW-1:0] volt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		volt_q <= div_side.rise ? div_side.base + div_q : div_side.base - div_q;
	end

	assign done    = done_q;
	assign volt_uv = volt_q;

	// every result comes from an earlier transfer, and every transfer produces one
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching request");

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("request produced no result");

	// requests at or beyond the table ends give the end voltages
	a_clamp_hi: assert property (@(posedge clk) disable iff (!arst_n)
		accept && freq_khz >= dvi_pkg::FREQ_TAB[0] |->
			##LAT volt_uv == dvi_pkg::VOLT_TAB[0])
		else $error("top clamp gave a wrong voltage");

	a_clamp_lo: assert property (@(posedge clk) disable iff (!arst_n)
		accept && freq_khz <= dvi_pkg::FREQ_TAB[LAST] |->
			##LAT volt_uv == dvi_pkg::VOLT_TAB[LAST])
		else $error("bottom clamp gave a wrong voltage");

endmodule

FILE: dv/tb_dvfs_voltage_interpolator_top.sv
// testbench for the frequency to supply voltage interpolator
`timescale 1ns / 1ps

// tracks requests in flight and checks each returned voltage against its own table walk
class volt_scoreboard;
	localparam int NPTS = 12;

	int unsigned freq_pt [NPTS] = '{
		2093000, 2002000, 1794000, 1540000, 1352000, 1014000,
		845000,  676000,  546000,  421000,  286000,  208000
	};
	int unsigned volt_pt [NPTS] = '{
		918750, 906250, 893750, 862500, 837500, 800000,
		781250, 756250, 700000, 725000, 712500, 700000
	};

	logic [19:0] volt_due [$];
	logic [23:0] freq_due [$];
	int          mismatches;

	function new();
		mismatches = 0;
	endfunction

	// piecewise linear lookup over the descending frequency points
	function logic [19:0] interp_volt(logic [23:0] f);
		longint unsigned fu, fd, vu, vd, span_f, delta_f, span_v, d;
		int              last;
		last = NPTS - 1;
		// clamp at both ends of the table
		if (f >= freq_pt[0])
			return 20'(volt_pt[0]);
		if (f <= freq_pt[last])
			return 20'(volt_pt[last]);
		for (int i = 1; i <= last; i++) begin
			fu = 64'(freq_pt[i-1]);
			fd = 64'(freq_pt[i]);
			vu = 64'(volt_pt[i-1]);
			vd = 64'(volt_pt[i]);
			if (f == fu)
				return vu[19:0];
			if (f == fd)
				return vd[19:0];
			if (f < fu && f > fd) begin
				span_f  = fu - fd;
				delta_f = fu - 64'(f);
				span_v  = (vu >= vd) ? vu - vd : vd - vu;
				d       = (span_v * delta_f) / span_f;
				return (vu >= vd) ? 20'(vu - d) : 20'(vu + d);
			end
		end
		return 20'(volt_pt[last]);
	endfunction

	task report(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	// accepted request transfer
	function void note_request(logic [23:0] f);
		freq_due.push_back(f);
		volt_due.push_back(interp_volt(f));
	endfunction

	// returned voltage transfer, compared with the oldest request
	task check_voltage(logic [19:0] v);
		logic [19:0] want;
		logic [23:0] f;
		if (volt_due.size() == 0) begin
			report($sformatf("unexpected volt_uv %0d", v));
			return;
		end
		want = volt_due.pop_front();
		f    = freq_due.pop_front();
		if (v !== want)
			report($sformatf("freq_khz %0d: volt_uv %0d, want %0d", f, v, want));
	endtask

	function int pending();
		return volt_due.size();
	endfunction
endclass

module tb_dvfs_voltage_interpolator_top;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [dvi_pkg::FW-1:0] freq_khz;
	logic                   done;
	logic [dvi_pkg::VW-1:0] volt_uv;

	volt_scoreboard sb;

	dvfs_voltage_interpolator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.freq_khz (freq_khz),
		.done     (done),
		.volt_uv  (volt_uv)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_voltage(volt_uv);
	end

	// drive one request after an idle gap, hold it until the transfer
	task send_request(logic [23:0] f, int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start    <= 1'b1;
		freq_khz <= f;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_request(f);
	endtask

	// let everything in flight come back
	task drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// random frequency: mostly inside the table, some near points, some anywhere, some below the table
	function logic [23:0] pick_freq();
		int unsigned sel, idx;
		sel = $urandom_range(0, 99);
		idx = $urandom_range(0, 11);
		if (sel < 60)
			return 24'($urandom_range(208000, 2093000));
		else if (sel < 75)
			return 24'(sb.freq_pt[idx] - 3 + $urandom_range(0, 6));
		else if (sel < 90)
			return 24'($urandom());
		else
			return 24'($urandom_range(0, 207999));
	endfunction

	logic [23:0] directed [$];

	initial begin
		int gap;
		sb       = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		freq_khz = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ends, exact points, one off the ends, a rising and a falling segment
		directed = '{24'd0, 24'hFFFFFF, 24'd2093001, 24'd2092999, 24'd208001, 24'd207999,
			24'd483500, 24'd353500, 24'd545999, 24'd421001};
		foreach (sb.freq_pt[i])
			directed.push_back(24'(sb.freq_pt[i]));
		foreach (directed[i])
			send_request(directed[i], i % 3);

		// the sender holds off until every result is back
		drain();

		// random part with stretches of back to back transfers
		for (int k = 0; k < 450; k++) begin
			gap = (k % 100 < 30) ? 0 : $urandom_range(0, 4);
			if (k == 225)
				drain();
			send_request(pick_freq(), gap);
		end
		drain();
		repeat (20) @(posedge clk);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never returned", sb.pending()));
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
